@@ hdl/urd_pkg.sv @@
// Shared constants, codes and control structs of the coin record decoder.
package urd_pkg;

  localparam int MAX_VARINT_BYTES = 10;
  localparam int MAX_SCRIPT_BYTES = 16384;
  localparam int PAY_W            = $clog2(MAX_SCRIPT_BYTES + 1);
  localparam int MAX_RESULTS      = 5;
  localparam int LIST_W           = $clog2(MAX_RESULTS + 1);
  localparam int IDX_W            = $clog2(MAX_RESULTS);

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_SCR = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_TRUNC    = 2'd1;
  localparam logic [1:0] ERR_OVERLONG = 2'd2;
  localparam logic [1:0] ERR_SCRIPT   = 2'd3;

  // Script kinds
  localparam logic [2:0] SK_P2PKH = 3'd0;
  localparam logic [2:0] SK_P2SH  = 3'd1;
  localparam logic [2:0] SK_PK2   = 3'd2;
  localparam logic [2:0] SK_PK3   = 3'd3;
  localparam logic [2:0] SK_PK4   = 3'd4;
  localparam logic [2:0] SK_PK5   = 3'd5;
  localparam logic [2:0] SK_RAW   = 3'd6;

  // Opcode bytes used by the script rebuild
  localparam logic [7:0] OPB_DUP    = 8'h76;
  localparam logic [7:0] OPB_HASH   = 8'hA9;
  localparam logic [7:0] OPB_PUSH20 = 8'h14;
  localparam logic [7:0] OPB_PUSH33 = 8'h21;
  localparam logic [7:0] OPB_EQ_VFY = 8'h88;
  localparam logic [7:0] OPB_CK_SIG = 8'hAC;
  localparam logic [7:0] OPB_EQ     = 8'h87;

  localparam logic [PAY_W-1:0] HASH_LEN = PAY_W'(20);
  localparam logic [PAY_W-1:0] KEY_LEN  = PAY_W'(32);

  // One queued result
  typedef struct packed {
    logic [1:0] kind;
    logic       use_data;
    logic [7:0] sbyte;
    logic [1:0] err;
    logic       rlast;
  } urd_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_byte;
    logic       clear_rec;
    logic       vi_step;
    logic       vi_inc;
    logic       vi_clear;
    logic       save_v0;
    logic       save_kind;
    logic       amt_start;
    logic       emit;
    urd_entry_t entry;
  } urd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             cont;
    logic [2:0]       kind;
    logic             raw_zero;
    logic             raw_big;
    logic [PAY_W-1:0] raw_len;
    logic [2:0]       skind;
    logic             amt_busy;
    logic             out_free;
  } urd_sts_t;

endpackage

@@ hdl/urd_amount.sv @@
// Multi-cycle amount decompression: shift-add division by ten and nine, then scale.
module urd_amount
  import urd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        clear_i,
  input  logic [63:0] x_i,
  output logic        busy_o,
  output logic [63:0] amount_o
);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_APX  = 3'd1;
  localparam logic [2:0] A_FIX  = 3'd2;
  localparam logic [2:0] A_MUL  = 3'd3;
  localparam logic [2:0] A_EXP  = 3'd4;

  logic [2:0]  st_q, st_d;
  logic        by9_q, by9_d;
  logic [2:0]  step_q, step_d;
  logic [63:0] src_q, src_d, t_q, t_d, n_q, n_d;
  logic [3:0]  r_q, r_d, e_q, e_d;
  logic [63:0] prod, rem, grow, dvs;

  // Quotient check and the growth term of the reciprocal series
  always_comb begin
    dvs  = by9_q ? 64'd9 : 64'd10;
    prod = by9_q ? ((t_q << 3) + t_q) : ((t_q << 3) + (t_q << 1));
    rem  = src_q - prod;
    case (step_q)
      3'd1:    grow = by9_q ? (t_q >> 6)  : (t_q >> 4);
      3'd2:    grow = by9_q ? (t_q >> 12) : (t_q >> 8);
      3'd3:    grow = by9_q ? (t_q >> 24) : (t_q >> 16);
      3'd4:    grow = by9_q ? (t_q >> 48) : (t_q >> 32);
      default: grow = '0;
    endcase
  end

  // Sequence the steps
  always_comb begin
    st_d   = st_q;
    by9_d  = by9_q;
    step_d = step_q;
    src_d  = src_q;
    t_d    = t_q;
    n_d    = n_q;
    r_d    = r_q;
    e_d    = e_q;
    case (st_q)
      A_IDLE: begin
        if (clear_i) n_d = '0;
        if (start_i) begin
          if (x_i == 64'd0) begin
            n_d = '0;
          end else begin
            src_d  = x_i - 64'd1;
            by9_d  = 1'b0;
            step_d = '0;
            st_d   = A_APX;
          end
        end
      end
      // Estimate the quotient from below, one series term a cycle
      A_APX: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: t_d = by9_q ? (src_q - (src_q >> 3)) : ((src_q >> 1) + (src_q >> 2));
          3'd5: begin
            t_d  = t_q >> 3;
            st_d = A_FIX;
          end
          default: t_d = t_q + grow;
        endcase
      end
      // Nudge the quotient until the remainder is in range
      A_FIX: begin
        if (rem[63]) begin
          t_d = t_q - 64'd1;
        end else if (rem >= dvs) begin
          t_d = t_q + 64'd1;
        end else if (!by9_q) begin
          e_d = rem[3:0];
          if (rem[3:0] < 4'd9) begin
            src_d  = t_q;
            by9_d  = 1'b1;
            step_d = '0;
            st_d   = A_APX;
          end else begin
            n_d  = t_q + 64'd1;
            st_d = A_EXP;
          end
        end else begin
          r_d  = rem[3:0];
          st_d = A_MUL;
        end
      end
      A_MUL: begin
        n_d  = (t_q << 3) + (t_q << 1) + {60'd0, r_q} + 64'd1;
        st_d = A_EXP;
      end
      A_EXP: begin
        if (e_q == 4'd0) begin
          st_d = A_IDLE;
        end else begin
          n_d = (n_q << 3) + (n_q << 1);
          e_d = e_q - 4'd1;
        end
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= A_IDLE;
      n_q  <= '0;
    end else begin
      st_q <= st_d;
      n_q  <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    by9_q  <= by9_d;
    step_q <= step_d;
    src_q  <= src_d;
    t_q    <= t_d;
    r_q    <= r_d;
    e_q    <= e_d;
  end

  assign busy_o   = (st_q != A_IDLE);
  assign amount_o = n_q;

endmodule

@@ hdl/urd_datapath.sv @@
// Datapath: byte register, varint accumulator, saved header fields, output register.
module urd_datapath
  import urd_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  urd_cmd_t       cmd_i,
  output urd_sts_t       sts_o,
  input  logic [7:0]     data_byte_i,
  input  logic           m_tready_i,
  output logic           m_tvalid_o,
  output logic [1:0]     item_kind_o,
  output logic [31:0]    block_height_o,
  output logic           is_coinbase_o,
  output logic [63:0]    amount_o,
  output logic [2:0]     script_kind_o,
  output logic [7:0]     script_byte_o,
  output logic           run_last_o,
  output logic           record_end_o,
  output logic [1:0]     error_code_o
);

  logic [7:0]  byte_q;
  logic [63:0] varint_q, vnew, raw_len64;
  logic [31:0] height_q;
  logic        cb_q;
  logic [2:0]  skind_q;
  logic [63:0] amt;
  logic        amt_busy;
  logic        ov_q;
  logic        hdr;

  assign vnew      = {varint_q[56:0], byte_q[6:0]};
  assign raw_len64 = vnew - 64'd6;

  urd_amount u_amount (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.amt_start),
    .clear_i  (cmd_i.clear_rec),
    .x_i      (vnew),
    .busy_o   (amt_busy),
    .amount_o (amt)
  );

  // Status back to the controller
  always_comb begin
    sts_o.cont     = byte_q[7];
    sts_o.kind     = (vnew < 64'd6) ? vnew[2:0] : SK_RAW;
    sts_o.raw_zero = (vnew == 64'd6);
    sts_o.raw_big  = (vnew > 64'(MAX_SCRIPT_BYTES + 6));
    sts_o.raw_len  = raw_len64[PAY_W-1:0];
    sts_o.skind    = skind_q;
    sts_o.amt_busy = amt_busy;
    sts_o.out_free = !ov_q || m_tready_i;
  end

  // Hold the request byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte) byte_q <= data_byte_i;
  end

  // Accumulate varints and save header fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      varint_q <= '0;
      height_q <= '0;
      cb_q     <= 1'b0;
      skind_q  <= '0;
    end else begin
      if (cmd_i.vi_clear) varint_q <= '0;
      else if (cmd_i.vi_step) varint_q <= vnew + {63'd0, cmd_i.vi_inc};
      if (cmd_i.clear_rec) begin
        height_q <= '0;
        cb_q     <= 1'b0;
        skind_q  <= '0;
      end
      if (cmd_i.save_v0) begin
        height_q <= vnew[32:1];
        cb_q     <= vnew[0];
      end
      if (cmd_i.save_kind) skind_q <= sts_o.kind;
    end
  end

  // Output register
  assign hdr = (cmd_i.entry.kind == KIND_HDR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (cmd_i.emit) ov_q <= 1'b1;
    else if (m_tready_i) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      item_kind_o    <= cmd_i.entry.kind;
      block_height_o <= hdr ? height_q : 32'd0;
      is_coinbase_o  <= hdr ? cb_q : 1'b0;
      amount_o       <= hdr ? amt : 64'd0;
      script_kind_o  <= hdr ? skind_q : 3'd0;
      script_byte_o  <= cmd_i.entry.use_data ? byte_q : cmd_i.entry.sbyte;
      run_last_o     <= cmd_i.entry.rlast;
      record_end_o   <= (cmd_i.entry.kind == KIND_END);
      error_code_o   <= cmd_i.entry.err;
    end
  end

  assign m_tvalid_o = ov_q;

endmodule

@@ hdl/urd_ctrl.sv @@
// Controller: parse phase, varint byte count, script length and result sequencing.
module urd_ctrl
  import urd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_tvalid_i,
  input  logic     s_tlast_i,
  output logic     s_tready_o,
  input  urd_sts_t sts_i,
  output urd_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DEC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [2:0] PH_V0    = 3'd0;
  localparam logic [2:0] PH_V1    = 3'd1;
  localparam logic [2:0] PH_V2    = 3'd2;
  localparam logic [2:0] PH_PAY   = 3'd3;
  localparam logic [2:0] PH_DRAIN = 3'd4;

  logic [1:0]        st_q, st_d;
  logic [2:0]        ph_q, ph_d;
  logic [3:0]        cnt_q, cnt_d;
  logic [PAY_W-1:0]  pay_q, pay_d, pay_dec;
  logic              last_q;
  urd_entry_t        lst_q [MAX_RESULTS];
  urd_entry_t        lst_d [MAX_RESULTS];
  logic [LIST_W-1:0] len_q, len_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              ended;
  logic              accept;

  assign s_tready_o = (st_q == S_IDLE) && !sts_i.amt_busy;
  assign accept     = s_tvalid_i && s_tready_o;

  // Decode one byte into parse updates and a result list
  always_comb begin
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    pay_d   = pay_q;
    len_d   = len_q;
    lst_d   = lst_q;
    ended   = 1'b0;
    pay_dec = '0;
    cmd_o   = '0;
    st_d    = st_q;
    idx_d   = idx_q;
    cmd_o.load_byte = accept;
    cmd_o.entry     = lst_q[idx_q];

    case (st_q)
      S_IDLE: begin
        if (accept) st_d = S_DEC;
      end
      S_DEC: begin
        len_d = '0;
        for (int i = 0; i < MAX_RESULTS; i++) lst_d[i] = '0;
        if (ph_q == PH_V0 && cnt_q == 4'd0) cmd_o.clear_rec = 1'b1;

        if (ph_q == PH_V0 || ph_q == PH_V1 || ph_q == PH_V2) begin
          cnt_d         = cnt_q + 4'd1;
          cmd_o.vi_step = 1'b1;
          if (sts_i.cont) begin
            if (cnt_d >= 4'(MAX_VARINT_BYTES)) begin
              lst_d[len_d] = '{KIND_END, 1'b0, 8'd0, ERR_OVERLONG, 1'b0};
              len_d = len_d + 1'b1;
              ended = 1'b1;
            end else begin
              cmd_o.vi_inc = 1'b1;
            end
          end else begin
            cmd_o.vi_clear = 1'b1;
            cnt_d          = '0;
            case (ph_q)
              PH_V0: begin
                cmd_o.save_v0 = 1'b1;
                ph_d          = PH_V1;
              end
              PH_V1: begin
                cmd_o.amt_start = 1'b1;
                ph_d            = PH_V2;
              end
              default: begin
                cmd_o.save_kind = 1'b1;
                lst_d[len_d] = '{KIND_HDR, 1'b0, 8'd0, ERR_OK, 1'b0};
                len_d = len_d + 1'b1;
                case (sts_i.kind)
                  SK_P2PKH: begin
                    lst_d[1] = '{KIND_SCR, 1'b0, OPB_DUP, ERR_OK, 1'b0};
                    lst_d[2] = '{KIND_SCR, 1'b0, OPB_HASH, ERR_OK, 1'b0};
                    lst_d[3] = '{KIND_SCR, 1'b0, OPB_PUSH20, ERR_OK, 1'b0};
                    len_d = LIST_W'(4);
                    pay_d = HASH_LEN;
                    ph_d  = PH_PAY;
                  end
                  SK_P2SH: begin
                    lst_d[1] = '{KIND_SCR, 1'b0, OPB_HASH, ERR_OK, 1'b0};
                    lst_d[2] = '{KIND_SCR, 1'b0, OPB_PUSH20, ERR_OK, 1'b0};
                    len_d = LIST_W'(3);
                    pay_d = HASH_LEN;
                    ph_d  = PH_PAY;
                  end
                  SK_PK2, SK_PK3: begin
                    lst_d[1] = '{KIND_SCR, 1'b0, OPB_PUSH33, ERR_OK, 1'b0};
                    lst_d[2] = '{KIND_SCR, 1'b0, {5'd0, sts_i.kind}, ERR_OK, 1'b0};
                    len_d = LIST_W'(3);
                    pay_d = KEY_LEN;
                    ph_d  = PH_PAY;
                  end
                  SK_PK4, SK_PK5: begin
                    pay_d = KEY_LEN;
                    ph_d  = PH_PAY;
                  end
                  default: begin
                    if (sts_i.raw_big) begin
                      lst_d[1] = '{KIND_END, 1'b0, 8'd0, ERR_SCRIPT, 1'b0};
                      len_d = LIST_W'(2);
                      ended = 1'b1;
                    end else if (sts_i.raw_zero) begin
                      lst_d[1] = '{KIND_END, 1'b0, 8'd0, ERR_OK, 1'b0};
                      len_d = LIST_W'(2);
                      ended = 1'b1;
                    end else begin
                      pay_d = sts_i.raw_len;
                      ph_d  = PH_PAY;
                    end
                  end
                endcase
              end
            endcase
          end
        end else if (ph_q == PH_PAY) begin
          if (sts_i.skind != SK_PK4 && sts_i.skind != SK_PK5) begin
            lst_d[len_d] = '{KIND_SCR, 1'b1, 8'd0, ERR_OK, 1'b0};
            len_d = len_d + 1'b1;
          end
          pay_dec = (pay_q != '0) ? (pay_q - 1'b1) : pay_q;
          pay_d   = pay_dec;
          if (pay_dec == '0) begin
            case (sts_i.skind)
              SK_P2PKH: begin
                lst_d[len_d] = '{KIND_SCR, 1'b0, OPB_EQ_VFY, ERR_OK, 1'b0};
                len_d = len_d + 1'b1;
                lst_d[len_d] = '{KIND_SCR, 1'b0, OPB_CK_SIG, ERR_OK, 1'b0};
                len_d = len_d + 1'b1;
              end
              SK_P2SH: begin
                lst_d[len_d] = '{KIND_SCR, 1'b0, OPB_EQ, ERR_OK, 1'b0};
                len_d = len_d + 1'b1;
              end
              SK_PK2, SK_PK3: begin
                lst_d[len_d] = '{KIND_SCR, 1'b0, OPB_CK_SIG, ERR_OK, 1'b0};
                len_d = len_d + 1'b1;
              end
              default: ;
            endcase
            lst_d[len_d] = '{KIND_END, 1'b0, 8'd0, ERR_OK, 1'b0};
            len_d = len_d + 1'b1;
            ended = 1'b1;
          end
        end

        // Close the record on an end or on the frame mark
        if (ended) begin
          cmd_o.vi_clear = 1'b1;
          cnt_d = '0;
          pay_d = '0;
          ph_d  = last_q ? PH_V0 : PH_DRAIN;
        end else if (last_q) begin
          if (ph_q != PH_DRAIN) begin
            lst_d[len_d] = '{KIND_END, 1'b0, 8'd0, ERR_TRUNC, 1'b0};
            len_d = len_d + 1'b1;
          end
          cmd_o.vi_clear = 1'b1;
          cnt_d = '0;
          pay_d = '0;
          ph_d  = PH_V0;
        end

        if (len_d != '0) begin
          lst_d[len_d - 1'b1].rlast = 1'b1;
          st_d  = S_EMIT;
          idx_d = '0;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + 1'b1;
          if (LIST_W'(idx_q) == len_q - 1'b1) st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= PH_V0;
      cnt_q  <= '0;
      pay_q  <= '0;
      len_q  <= '0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      pay_q <= pay_d;
      len_q <= len_d;
      idx_q <= idx_d;
      if (accept) last_q <= s_tlast_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lst_q <= lst_d;
  end

  // A result is emitted only from the result sequence
  a_emit_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (st_q == S_EMIT))
    else $error("emit outside result sequence");

  // No new request while the amount unit runs
  a_busy_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.amt_busy |-> !s_tready_o)
    else $error("request taken while amount busy");

  // The list never exceeds the result bound
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LIST_W'(MAX_RESULTS))
    else $error("result list overflow");

  // A decode step always follows an accepted request
  a_dec_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (st_q == S_DEC))
    else $error("decode skipped");

endmodule

@@ hdl/utxo_record_decoder.sv @@
// Top level of the stored coin record decoder.
//
// Input stream: one record byte per request on s_axis (tdata[7:0]), tlast on the
// final byte of a record. Output stream: results on m_axis, tuser holds the kind
// (header, script byte, end marker), tlast marks the record end marker.
// Each accepted byte is decoded in the cycle after it is taken and its results
// (none to five) leave through the output register, one per cycle while the
// receiver is ready. The byte that ends the amount varint starts the amount
// unit, which divides by ten and nine with shift-add estimates corrected by a
// few compare steps and then scales by ten per exponent step: it holds off the
// next byte while it runs, once per record.
// Reset returns the decoder to the first varint of a new record and empties the
// output register. When the receiver stalls, the current result holds in the
// output register, the result sequence waits and no new byte is taken.
// Bytes after an ended record are dropped without results until tlast.
module utxo_record_decoder
  import urd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] data_byte
  input  logic         s_axis_tlast_i,   // record_last
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [31:0] block_height, [32] is_coinbase, [96:33] amount, [99:97] script_kind,
  // [107:100] script_byte, [108] run_last, [110:109] error_code, [111] zero
  output logic [111:0] m_axis_tdata_o,
  output logic [1:0]   m_axis_tuser_o,   // [1:0] item_kind
  output logic         m_axis_tlast_o    // record_end
);

  urd_cmd_t    cmd;
  urd_sts_t    sts;
  logic [31:0] height;
  logic        cb;
  logic [63:0] amt;
  logic [2:0]  skind;
  logic [7:0]  sbyte;
  logic        rlast;
  logic [1:0]  err;

  urd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tlast_i  (s_axis_tlast_i),
    .s_tready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  urd_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (s_axis_tdata_i),
    .m_tready_i     (m_axis_tready_i),
    .m_tvalid_o     (m_axis_tvalid_o),
    .item_kind_o    (m_axis_tuser_o),
    .block_height_o (height),
    .is_coinbase_o  (cb),
    .amount_o       (amt),
    .script_kind_o  (skind),
    .script_byte_o  (sbyte),
    .run_last_o     (rlast),
    .record_end_o   (m_axis_tlast_o),
    .error_code_o   (err)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {1'b0, err, rlast, sbyte, skind, amt, cb, height};

endmodule

@@ tb/urd_checker.sv @@
// Result predictor and comparator for the coin record decoder.
`timescale 1ns / 1ps
module urd_checker
  import urd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [7:0]   s_data_i,
  input  logic         s_last_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [111:0] m_data_i,
  input  logic [1:0]   m_user_i,
  input  logic         m_last_i,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] height;
    logic        coinbase;
    logic [63:0] amount;
    logic [2:0]  skind;
    logic [7:0]  sbyte;
    logic        rlast;
    logic        rend;
    logic [1:0]  err;
  } dec_result_t;

  localparam logic [2:0] PH_HEIGHT = 3'd0;
  localparam logic [2:0] PH_AMOUNT = 3'd1;
  localparam logic [2:0] PH_KIND   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;

  dec_result_t result_q[$];
  logic [2:0]  phase;
  logic [63:0] acc;
  logic [3:0]  acc_cnt;
  logic [31:0] h_r;
  logic        cb_r;
  logic [63:0] amt_r;
  logic [2:0]  sk_r;
  logic [15:0] remain;
  int          fails;
  dec_result_t step_q[$];

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();

  function automatic logic [63:0] expand_amount(logic [63:0] x);
    logic [63:0] e, n, d;
    if (x == 0) return 0;
    x = x - 1;
    e = x % 10;
    x = x / 10;
    if (e < 9) begin
      d = (x % 9) + 1;
      x = x / 9;
      n = x * 10 + d;
    end else begin
      n = x + 1;
    end
    while (e != 0) begin
      n = n * 10;
      e = e - 1;
    end
    return n;
  endfunction

  task automatic push_result(logic [1:0] kind, logic [7:0] sb, logic [1:0] err);
    dec_result_t r;
    r = '0;
    r.kind = kind;
    r.sbyte = sb;
    r.rend = (kind == KIND_END);
    r.err = err;
    if (kind == KIND_HDR) begin
      r.height = h_r;
      r.coinbase = cb_r;
      r.amount = amt_r;
      r.skind = sk_r;
    end
    step_q = {step_q, r};
  endtask

  // Predict the results of one accepted record byte
  task automatic decode_byte(logic [7:0] b, logic last);
    logic        ended;
    logic [63:0] v;
    ended = 1'b0;
    step_q = {};
    if (phase == PH_HEIGHT && acc_cnt == 0) begin
      h_r = 0; cb_r = 0; amt_r = 0; sk_r = 0; remain = 0;
    end
    if (phase <= PH_KIND) begin
      acc = (acc << 7) | {57'd0, b[6:0]};
      acc_cnt = acc_cnt + 1;
      if (b[7]) begin
        if (acc_cnt >= MAX_VARINT_BYTES) begin
          push_result(KIND_END, 0, ERR_OVERLONG);
          ended = 1'b1;
        end else begin
          acc = acc + 1;
        end
      end else begin
        v = acc;
        acc = 0;
        acc_cnt = 0;
        if (phase == PH_HEIGHT) begin
          h_r = v[32:1];
          cb_r = v[0];
          phase = PH_AMOUNT;
        end else if (phase == PH_AMOUNT) begin
          amt_r = expand_amount(v);
          phase = PH_KIND;
        end else begin
          sk_r = (v < 6) ? v[2:0] : SK_RAW;
          push_result(KIND_HDR, 0, ERR_OK);
          if (sk_r == SK_RAW) begin
            if (v - 6 > MAX_SCRIPT_BYTES) begin
              push_result(KIND_END, 0, ERR_SCRIPT);
              ended = 1'b1;
            end else if (v == 6) begin
              push_result(KIND_END, 0, ERR_OK);
              ended = 1'b1;
            end else begin
              remain = 16'(v - 6);
              phase = PH_BODY;
            end
          end else begin
            case (sk_r)
              SK_P2PKH: begin
                push_result(KIND_SCR, OPB_DUP, ERR_OK);
                push_result(KIND_SCR, OPB_HASH, ERR_OK);
                push_result(KIND_SCR, OPB_PUSH20, ERR_OK);
                remain = 20;
              end
              SK_P2SH: begin
                push_result(KIND_SCR, OPB_HASH, ERR_OK);
                push_result(KIND_SCR, OPB_PUSH20, ERR_OK);
                remain = 20;
              end
              SK_PK2, SK_PK3: begin
                push_result(KIND_SCR, OPB_PUSH33, ERR_OK);
                push_result(KIND_SCR, {5'd0, sk_r}, ERR_OK);
                remain = 32;
              end
              default: remain = 32;
            endcase
            phase = PH_BODY;
          end
        end
      end
    end else if (phase == PH_BODY) begin
      if (sk_r != SK_PK4 && sk_r != SK_PK5) push_result(KIND_SCR, b, ERR_OK);
      if (remain > 0) remain = remain - 1;
      if (remain == 0) begin
        case (sk_r)
          SK_P2PKH: begin
            push_result(KIND_SCR, OPB_EQ_VFY, ERR_OK);
            push_result(KIND_SCR, OPB_CK_SIG, ERR_OK);
          end
          SK_P2SH: push_result(KIND_SCR, OPB_EQ, ERR_OK);
          SK_PK2, SK_PK3: push_result(KIND_SCR, OPB_CK_SIG, ERR_OK);
          default: ;
        endcase
        push_result(KIND_END, 0, ERR_OK);
        ended = 1'b1;
      end
    end
    if (ended) begin
      acc = 0; acc_cnt = 0; remain = 0;
      phase = last ? PH_HEIGHT : PH_SKIP;
    end else if (last) begin
      if (phase != PH_SKIP) push_result(KIND_END, 0, ERR_TRUNC);
      acc = 0; acc_cnt = 0; remain = 0;
      phase = PH_HEIGHT;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].rlast = 1'b1;
    result_q = {result_q, step_q};
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_result();
    dec_result_t got, want;
    got.kind = m_user_i;
    got.height = m_data_i[31:0];
    got.coinbase = m_data_i[32];
    got.amount = m_data_i[96:33];
    got.skind = m_data_i[99:97];
    got.sbyte = m_data_i[107:100];
    got.rlast = m_data_i[108];
    got.err = m_data_i[110:109];
    got.rend = m_last_i;
    if (result_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
    end else begin
      want = result_q.pop_front();
      if (got !== want || m_data_i[111] !== 1'b0) begin
        fails++;
        $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase <= PH_HEIGHT;
      acc <= 0; acc_cnt <= 0; h_r <= 0; cb_r <= 0; amt_r <= 0; sk_r <= 0;
      remain <= 0; fails <= 0;
      result_q = {};
    end else begin
      if (m_valid_i && m_ready_i) check_result();
      if (s_valid_i && s_ready_i) decode_byte(s_data_i, s_last_i);
    end
  end

endmodule

@@ tb/tb_utxo_record_decoder.sv @@
// Stimulus and verdict for the coin record decoder.
`timescale 1ns / 1ps
module tb_utxo_record_decoder
  import urd_pkg::*;
();

  localparam int IDLE_LIMIT = 20000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [7:0]   s_data = '0;
  logic         s_last = 1'b0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [111:0] m_data;
  logic [1:0]   m_user;
  logic         m_last;
  int           fail_count;
  int           pending;
  int           idle_cycles = 0;
  int           sent = 0;
  bit           calm = 1'b0;
  bit           hold_rx = 1'b0;
  bit           stim_done = 1'b0;
  logic [7:0]   rec_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  utxo_record_decoder uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  urd_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_last_i(s_last),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .m_user_i(m_user), .m_last_i(m_last),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stalls, none while calm, long hold when asked
  always @(negedge clk_i) begin
    if (hold_rx) m_ready <= 1'b0;
    else m_ready <= calm || ($urandom_range(99) >= 8);
  end

  // Watchdog on cycles without any transfer on either stream
  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_utxo_record_decoder: errors");
      $finish;
    end
  end

  // Send one byte, inserting random gaps before it
  task automatic send_byte(logic [7:0] b, logic last);
    while (!calm && $urandom_range(99) < 8) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data <= b;
    s_last <= last;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Append a varint in the continuation form
  task automatic add_varint(logic [63:0] n);
    logic [7:0] tmp[$];
    tmp.push_front({1'b0, n[6:0]});
    while (n > 127) begin
      n = (n >> 7) - 1;
      tmp.push_front({1'b1, n[6:0]});
    end
    rec_q = {rec_q, tmp};
  endtask

  task automatic send_record();
    foreach (rec_q[i]) send_byte(rec_q[i], i == rec_q.size() - 1);
    rec_q = {};
  endtask

  function automatic logic [63:0] rand_wide();
    case ($urandom_range(3))
      0: return $urandom_range(127);
      1: return $urandom_range(20000);
      2: return $urandom;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Build a well-formed record with random content
  task automatic build_record(int kind_sel);
    int plen, n;
    add_varint(rand_wide());
    add_varint(rand_wide());
    if (kind_sel < 6) begin
      add_varint(kind_sel);
      plen = (kind_sel < 2) ? 20 : 32;
    end else begin
      plen = $urandom_range(6);
      add_varint(plen + 6);
    end
    for (n = 0; n < plen; n++) rec_q = {rec_q, 8'($urandom)};
  endtask

  int rec_n, k, cut;

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: extremes and error cases
    add_varint(0); add_varint(0); add_varint(6); send_record();
    for (k = 0; k < 12; k++) rec_q = {rec_q, 8'hFF};
    rec_q = {rec_q, 8'h00}; send_record();
    add_varint(64'hFFFF_FFFF_FFFF_FFFF); add_varint(64'hFFFF_FFFF_FFFF_FFFF);
    add_varint(MAX_SCRIPT_BYTES + 7); rec_q = {rec_q, 8'h55}; send_record();
    add_varint(3); add_varint(9); send_record();
    send_byte(8'h80, 1'b1);
    add_varint(1); add_varint(1); add_varint(0);
    for (k = 0; k < 20; k++) rec_q = {rec_q, 8'hAA};
    rec_q = {rec_q, 8'h01, 8'h02}; send_record();

    // Long receiver hold while the sender keeps offering
    fork
      begin
        hold_rx = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      begin
        build_record(4);
        send_record();
      end
    join

    // Random: every script kind in turn, some truncated or noisy
    rec_n = 0;
    while (sent < 260) begin
      calm = (sent > 120 && sent < 170);
      build_record((rec_n + 5) % 7);
      rec_n++;
      case ($urandom_range(9))
        0: begin
          cut = $urandom_range(rec_q.size() - 1) + 1;
          while (rec_q.size() > cut) void'(rec_q.pop_back());
        end
        1: rec_q[$urandom_range(rec_q.size() - 1)] = 8'($urandom);
        2: for (k = 0; k < 3; k++) rec_q = {rec_q, 8'($urandom)};
        default: ;
      endcase
      send_record();
    end
    s_valid <= 1'b0;
    calm = 1'b0;
    stim_done = 1'b1;
  end

  // Verdict after the queue drains plus a settling interval
  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_utxo_record_decoder: clean");
    end else begin
      $display("tb_utxo_record_decoder: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/urd_pkg.sv
hdl/urd_amount.sv
hdl/urd_datapath.sv
hdl/urd_ctrl.sv
hdl/utxo_record_decoder.sv
tb/urd_checker.sv
tb/tb_utxo_record_decoder.sv
